### hw/rtl/spf_pkg.sv
`default_nettype none
package spf_pkg;

  // table geometry
  localparam int TableSize = 262144;
  localparam int AddrW     = $clog2(TableSize);
  localparam int IdxW      = AddrW + 1;
  localparam int RootW     = (AddrW + 1) / 2 + 1;

  // field widths
  localparam int ValW = 18;
  localparam int CntW = $clog2(ValW + 1);

  // controller states
  typedef enum logic [3:0] {
    ST_FILL,
    ST_ISEL,
    ST_ICHK,
    ST_JRD,
    ST_JWR,
    ST_IDLE,
    ST_LOOK,
    ST_LGOT,
    ST_DIV
  } state_t;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FILL,
    OP_READ_I,
    OP_NEXT_I,
    OP_READ_J,
    OP_MARK_J,
    OP_ACCEPT,
    OP_ACCEPT_NOF,
    OP_READ_N,
    OP_EMIT_LAST,
    OP_NEW_PRIME,
    OP_DIV_AGAIN,
    OP_DIV_TAKE
  } dp_op_t;

  // datapath status
  typedef struct packed {
    logic fill_last;
    logic sieve_done;
    logic i_prime;
    logic j_end;
    logic trivial;
    logic n_one;
    logic d_new;
    logic div_done;
  } dp_status_t;

endpackage
`default_nettype wire

### hw/rtl/spf_div.sv
`default_nettype none
module spf_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [spf_pkg::ValW-1:0] dividend,
  input  wire logic [spf_pkg::ValW-1:0] divisor,
  output logic      [spf_pkg::ValW-1:0] quotient,
  output logic                          done
);
  import spf_pkg::*;

  logic [ValW-1:0] rem;
  logic [ValW-1:0] quo;
  logic [CntW-1:0] cnt;
  logic [ValW:0]   shifted;
  logic [ValW:0]   diff;
  logic            ge;

  // one restoring step per cycle
  assign shifted  = {rem, quo[ValW-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign diff     = shifted - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= dividend;
        cnt <= CntW'(ValW);
      end else if (cnt != '0) begin
        rem  <= ge ? diff[ValW-1:0] : shifted[ValW-1:0];
        quo  <= {quo[ValW-2:0], ge};
        cnt  <= cnt - 1'b1;
        done <= cnt == CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/spf_datapath.sv
`default_nettype none
module spf_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire spf_pkg::dp_op_t          op,
  output spf_pkg::dp_status_t           status,
  input  wire logic [spf_pkg::ValW-1:0] value,
  output logic                          valid,
  output logic      [spf_pkg::ValW-1:0] prime,
  output logic                          no_factor,
  output logic                          last
);
  import spf_pkg::*;

  // factor table
  logic [AddrW-1:0] mem [TableSize];
  logic [AddrW-1:0] rdata;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] wdata;
  logic             we;

  // sieve counters
  logic [RootW-1:0]   i;
  logic [IdxW-1:0]    j;
  logic [2*RootW-1:0] sq;

  // factoring state
  logic [ValW-1:0] n;
  logic [ValW-1:0] p;
  logic            have_pend;
  logic [ValW-1:0] quotient;
  logic            div_done;
  logic            div_start;

  assign sq = (2*RootW)'(i) * (2*RootW)'(i);

  // table port control
  always_comb begin
    unique case (op)
      OP_READ_I: raddr = AddrW'(i);
      OP_READ_J: raddr = AddrW'(j);
      default:   raddr = AddrW'(n);
    endcase
    waddr = AddrW'(j);
    wdata = (op == OP_FILL) ? AddrW'(j) : AddrW'(i);
    we    = (op == OP_FILL) || ((op == OP_MARK_J) && (rdata == AddrW'(j)));
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // divider for stripping a prime from the cofactor
  assign div_start = (op == OP_NEW_PRIME) || (op == OP_DIV_AGAIN);

  spf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (ValW'(rdata)),
    .quotient (quotient),
    .done     (div_done)
  );

  // status back to the controller
  always_comb begin
    status.fill_last  = int'(j) == TableSize - 1;
    status.sieve_done = int'(sq) >= TableSize;
    status.i_prime    = rdata == AddrW'(i);
    status.j_end      = int'(j) >= TableSize;
    status.trivial    = (value <= ValW'(1)) || (int'(value) >= TableSize);
    status.n_one      = n == ValW'(1);
    status.d_new      = !have_pend || (ValW'(rdata) != p);
    status.div_done   = div_done;
  end

  // counters, cofactor and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      i         <= RootW'(2);
      j         <= '0;
      valid     <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (op)
        OP_FILL:   j <= j + 1'b1;
        OP_READ_I: j <= IdxW'(sq);
        OP_NEXT_I: i <= i + 1'b1;
        OP_MARK_J: j <= j + IdxW'(i);
        OP_ACCEPT: begin
          n         <= value;
          have_pend <= 1'b0;
        end
        OP_ACCEPT_NOF: begin
          valid     <= 1'b1;
          prime     <= '0;
          no_factor <= 1'b1;
          last      <= 1'b1;
        end
        OP_EMIT_LAST: begin
          valid     <= 1'b1;
          prime     <= p;
          no_factor <= 1'b0;
          last      <= 1'b1;
        end
        OP_NEW_PRIME: begin
          valid     <= have_pend;
          prime     <= p;
          no_factor <= 1'b0;
          last      <= 1'b0;
          p         <= ValW'(rdata);
          have_pend <= 1'b1;
        end
        OP_DIV_TAKE: n <= quotient;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/spf_ctrl.sv
`default_nettype none
module spf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire spf_pkg::dp_status_t status,
  output spf_pkg::dp_op_t          op,
  output logic                     busy
);
  import spf_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    busy       = state != ST_IDLE;
    unique case (state)
      ST_FILL: begin
        op = OP_FILL;
        if (status.fill_last) begin
          state_next = ST_ISEL;
        end
      end
      ST_ISEL: begin
        if (status.sieve_done) begin
          state_next = ST_IDLE;
        end else begin
          op         = OP_READ_I;
          state_next = ST_ICHK;
        end
      end
      ST_ICHK: begin
        if (status.i_prime) begin
          state_next = ST_JRD;
        end else begin
          op         = OP_NEXT_I;
          state_next = ST_ISEL;
        end
      end
      ST_JRD: begin
        if (status.j_end) begin
          op         = OP_NEXT_I;
          state_next = ST_ISEL;
        end else begin
          op         = OP_READ_J;
          state_next = ST_JWR;
        end
      end
      ST_JWR: begin
        op         = OP_MARK_J;
        state_next = ST_JRD;
      end
      ST_IDLE: begin
        if (start) begin
          if (status.trivial) begin
            op = OP_ACCEPT_NOF;
          end else begin
            op         = OP_ACCEPT;
            state_next = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        op         = OP_READ_N;
        state_next = ST_LGOT;
      end
      ST_LGOT: begin
        priority if (status.n_one) begin
          op         = OP_EMIT_LAST;
          state_next = ST_IDLE;
        end else if (status.d_new) begin
          op         = OP_NEW_PRIME;
          state_next = ST_DIV;
        end else begin
          op         = OP_DIV_AGAIN;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          op         = OP_DIV_TAKE;
          state_next = ST_LOOK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/spf_sieve_prime_factorizer_core.sv
// smallest-prime-factor sieve factorizer
//
// input: value is taken at a rising edge with start high and busy low
// output: each distinct prime factor of value appears on prime for one
//   cycle with valid high, in ascending order; last marks the final one
//   for the transaction; a value of 0 or 1 gives one result with prime 0,
//   no_factor 1 and last 1, in the cycle after the one with start
// reset: busy stays high while the factor table is built, first a fill
//   pass over all TableSize entries (one entry per cycle), then the sieve,
//   a table read and a conditional write per visited multiple of each
//   prime below sqrt(TableSize)
// per value: each factor occurrence (prime factors counted with
//   multiplicity) costs one table lookup and one division on the single
//   radix-2 divider, plus a final lookup before the last result
// throughput: one value at a time; busy is high until the last result,
//   but stays low for 0 or 1; the receiver cannot stall: results are not held back
`default_nettype none
module spf_sieve_prime_factorizer_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [spf_pkg::ValW-1:0] value,
  output logic                          valid,
  output logic      [spf_pkg::ValW-1:0] prime,
  output logic                          no_factor,
  output logic                          last
);
  import spf_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  // sequencer
  spf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy)
  );

  // table, divider and result registers
  spf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .value     (value),
    .valid     (valid),
    .prime     (prime),
    .no_factor (no_factor),
    .last      (last)
  );

endmodule
`default_nettype wire

### hw/rtl/spf_checker.sv
`default_nettype none
module spf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [17:0] value,
  input wire logic        valid,
  input wire logic [17:0] prime,
  input wire logic        no_factor,
  input wire logic        last
);

  // table build holds the block off after reset
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // a no-factor result stands alone
  a_nof_alone: assert property (@(posedge clk) disable iff (rst)
    valid && no_factor |-> last && (prime == 18'd0))
    else $error("no-factor result not single");

  // a real factor is at least two
  a_prime_min: assert property (@(posedge clk) disable iff (rst)
    valid && !no_factor |-> prime >= 18'd2)
    else $error("factor below two");

  // more results pending keeps the block busy
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> busy)
    else $error("idle before last result");

  // zero or one answers in the next cycle
  a_trivial: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (value <= 18'd1) |=> valid && no_factor)
    else $error("missing no-factor result");

endmodule

bind spf_sieve_prime_factorizer_core spf_checker u_chk (.*);
`default_nettype wire
